// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the range-sum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition leads to a consequence on the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mfrs_pkg.sv =====
// Shared constants and types of the modular Fenwick range-sum block.
`default_nettype none

package mfrs_pkg;

  localparam int SIZE   = 1024;
  localparam int IDX_W  = $clog2(SIZE);
  localparam int DATA_W = 30;

  localparam logic [DATA_W-1:0] MOD_P = 30'd1000000007;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic {
    MOP_ADD = 1'b0,
    MOP_SUB = 1'b1
  } mod_op_t;

  typedef struct packed {
    mod_op_t             op;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
  } mod_req_t;

endpackage

`default_nettype wire

// ===== rtl/mfrs_mod_unit.sv =====
// Shared modular adder and subtractor over the prime modulus.
`default_nettype none

module mfrs_mod_unit (
  input  mfrs_pkg::mod_req_t               req,
  output logic [mfrs_pkg::DATA_W-1:0]      res
);

  logic [mfrs_pkg::DATA_W:0] sum;
  logic [mfrs_pkg::DATA_W:0] diff;
  logic [mfrs_pkg::DATA_W:0] sum_red;
  logic [mfrs_pkg::DATA_W:0] diff_fix;

  always_comb begin
    sum      = {1'b0, req.a} + {1'b0, req.b};
    diff     = {1'b0, req.a} - {1'b0, req.b};
    sum_red  = (sum >= {1'b0, mfrs_pkg::MOD_P}) ? sum - {1'b0, mfrs_pkg::MOD_P} : sum;
    diff_fix = diff[mfrs_pkg::DATA_W] ? diff + {1'b0, mfrs_pkg::MOD_P} : diff;
    case (req.op)
      mfrs_pkg::MOP_ADD: res = sum_red[mfrs_pkg::DATA_W-1:0];
      mfrs_pkg::MOP_SUB: res = diff_fix[mfrs_pkg::DATA_W-1:0];
      default:           res = sum_red[mfrs_pkg::DATA_W-1:0];
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mfrs_ctrl.sv =====
// Sequencer and node memory that walk the tree for add and query items.
`default_nettype none

module mfrs_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic                             cmd,
  input  logic [mfrs_pkg::IDX_W-1:0]       update_index,
  input  logic [mfrs_pkg::DATA_W-1:0]      addend,
  input  logic [mfrs_pkg::IDX_W-1:0]       range_low,
  input  logic [mfrs_pkg::IDX_W-1:0]       range_high,
  output mfrs_pkg::mod_req_t               mod_req,
  input  logic [mfrs_pkg::DATA_W-1:0]      mod_res,
  output logic                             res_valid,
  output logic [mfrs_pkg::DATA_W-1:0]      res_data,
  input  logic                             res_ready
);

  `include "assert_macros.svh"

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADD   = 6'b000100,
    S_QHI   = 6'b001000,
    S_QLO   = 6'b010000,
    S_DIFF  = 6'b100000
  } state_t;

  state_t                          state;
  logic [mfrs_pkg::IDX_W:0]        iss;
  logic [mfrs_pkg::IDX_W:0]        low_bit;
  logic                            walk_live;
  logic                            pend_vld;
  logic [mfrs_pkg::IDX_W-1:0]      pend_idx;
  logic [mfrs_pkg::DATA_W-1:0]     addv;
  logic [mfrs_pkg::DATA_W-1:0]     acc;
  logic [mfrs_pkg::DATA_W-1:0]     p_hi;
  logic [mfrs_pkg::IDX_W-1:0]      lo_first;
  logic [mfrs_pkg::IDX_W-1:0]      clr_cnt;
  logic [mfrs_pkg::DATA_W-1:0]     mem [mfrs_pkg::SIZE];
  logic [mfrs_pkg::DATA_W-1:0]     rd_data;
  logic                            we;
  logic [mfrs_pkg::IDX_W-1:0]      wa;
  logic [mfrs_pkg::DATA_W-1:0]     wd;

  assign walk_live  = !iss[mfrs_pkg::IDX_W] && (iss[mfrs_pkg::IDX_W-1:0] != '0);
  assign low_bit    = iss & (~iss + 1'b1);
  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_DIFF);
  assign res_data   = mod_res;

  always_comb begin
    mod_req.op = mfrs_pkg::MOP_ADD;
    mod_req.a  = acc;
    mod_req.b  = rd_data;
    we         = 1'b0;
    wa         = pend_idx;
    wd         = mod_res;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
        wd = '0;
      end
      S_IDLE: begin
        mod_req.a = addend;
        mod_req.b = '0;
      end
      S_ADD: begin
        mod_req.a = rd_data;
        mod_req.b = addv;
        we        = pend_vld;
      end
      S_DIFF: begin
        mod_req.op = mfrs_pkg::MOP_SUB;
        mod_req.a  = p_hi;
        mod_req.b  = acc;
      end
      default: begin
        mod_req.a = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[iss[mfrs_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      pend_vld <= 1'b0;
      acc      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == mfrs_pkg::IDX_W'(mfrs_pkg::SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            if (cmd == mfrs_pkg::CMD_ADD) begin
              addv  <= mod_res;
              iss   <= {1'b0, update_index};
              state <= S_ADD;
            end else begin
              iss      <= {1'b0, range_high};
              lo_first <= (range_low == '0) ? '0 : range_low - 1'b1;
              acc      <= '0;
              state    <= S_QHI;
            end
          end
        end
        S_ADD, S_QHI, S_QLO: begin
          pend_vld <= walk_live;
          pend_idx <= iss[mfrs_pkg::IDX_W-1:0];
          if (walk_live) begin
            iss <= (state == S_ADD) ? iss + low_bit : iss - low_bit;
          end
          if (pend_vld && state != S_ADD) begin
            acc <= mod_res;
          end
          if (!walk_live && !pend_vld) begin
            case (state)
              S_ADD: begin
                state <= S_IDLE;
              end
              S_QHI: begin
                p_hi  <= acc;
                acc   <= '0;
                iss   <= {1'b0, lo_first};
                state <= S_QLO;
              end
              default: begin
                state <= S_DIFF;
              end
            endcase
          end
        end
        S_DIFF: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          clr_cnt <= '0;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_acc_reduced, acc < mfrs_pkg::MOD_P, "accumulator left the residue range")
  `ASSERT_ALWAYS(a_pend_in_walk,
                 !pend_vld || state == S_ADD || state == S_QHI || state == S_QLO,
                 "memory read pending outside a tree walk")
  `ASSERT_ALWAYS(a_write_nonzero, !(state == S_ADD && we) || wa != '0,
                 "add walk wrote node zero")
  `ASSERT_NEXT(a_clear_done,
               state == S_CLEAR && clr_cnt == mfrs_pkg::IDX_W'(mfrs_pkg::SIZE - 1),
               item_ready, "block not ready after the clearing pass")

endmodule

`default_nettype wire

// ===== rtl/modular_fenwick_range_sum.sv =====
// Top level of the modular Fenwick range-sum block with its result register.
//
// After reset the block clears its 1024 tree nodes, one per cycle, and takes
// no item until the clearing is done. An item is taken in a cycle in which
// the block is idle. An add item then keeps it busy while it walks up the
// tree through at most 10 nodes. A range query keeps it busy while it makes
// its two prefix walks (at most 10 and 9 nodes), and longer while its sum
// cannot move into the output register. The pace is set by the node memory,
// which serves one node read per cycle, and by the one shared modular adder.
// A finished sum sits in an output register, so the next item may start
// while the sum waits to be taken.
`default_nettype none

module modular_fenwick_range_sum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic                             cmd,
  input  logic [mfrs_pkg::IDX_W-1:0]       update_index,
  input  logic [mfrs_pkg::DATA_W-1:0]      addend,
  input  logic [mfrs_pkg::IDX_W-1:0]       range_low,
  input  logic [mfrs_pkg::IDX_W-1:0]       range_high,
  output logic                             sum_valid,
  input  logic                             sum_ready,
  output logic [mfrs_pkg::DATA_W-1:0]      range_sum
);

  mfrs_pkg::mod_req_t               mod_req;
  logic [mfrs_pkg::DATA_W-1:0]      mod_res;
  logic                             res_valid;
  logic [mfrs_pkg::DATA_W-1:0]      res_data;
  logic                             res_ready;

  assign res_ready = !sum_valid || sum_ready;

  mfrs_mod_unit u_mod (
    .req (mod_req),
    .res (mod_res)
  );

  mfrs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cmd          (cmd),
    .update_index (update_index),
    .addend       (addend),
    .range_low    (range_low),
    .range_high   (range_high),
    .mod_req      (mod_req),
    .mod_res      (mod_res),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .res_ready    (res_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      sum_valid <= 1'b1;
      range_sum <= res_data;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
